[sv/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon ray casting block.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Coordinate and arithmetic widths
    localparam int COORD_W      = 13;           // signed vertex / query coordinate
    localparam int DIFF_W       = COORD_W + 1;  // difference of two coordinates
    localparam int RAYD_W       = 16;           // ray end x minus a coordinate
    localparam int RAY_END_X    = 10000;        // far end of the horizontal ray
    localparam int MIN_VERTICES = 3;

    // Pipeline depth of the edge unit after the first stage
    localparam int DRAIN_CYCLES = 2;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        ORI_COLIN,
        ORI_CW,
        ORI_CCW
    } t_orient;

    // One polygon edge from vertex a to vertex b
    typedef struct packed {
        logic                       valid;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
    } t_edge;

    function automatic t_orient orient_of(input logic is_zero, input logic is_neg);
        t_orient res;
        if (is_zero) begin
            res = ORI_COLIN;
        end else if (is_neg) begin
            res = ORI_CCW;
        end else begin
            res = ORI_CW;
        end
        return res;
    endfunction

endpackage

[sv/point_in_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Clear and append leave the block idle, so a new item may follow at once.
// A query walks the scan, drain and finish states; the block turns idle in the
// same cycle that its result appears on the output, and it holds in finish while
// the output stalls. The vertex ring rotates one cell per cycle past the edge unit.
// Reset clears vertex count, overflow flag, FSM and output valid; cells hold.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_mode,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_px,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_py,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_inside_res,
    output logic                                o_too_few_vertices,
    output logic                                o_overflowed
);

    localparam int CW = $clog2(MAX_VERTICES + 1);   // vertex count
    localparam int SW = $clog2(MAX_VERTICES);       // scan step / cell index

    // Control state
    pip_pkg::t_state                r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_overflow, n_overflow;
    logic [SW-1:0]                  r_step, n_step;
    logic [pip_pkg::DRAIN_W-1:0]    r_drain, n_drain;
    logic                           r_out_valid, n_out_valid;

    // Query context and result payload
    logic signed [pip_pkg::COORD_W-1:0] r_qx, r_qy, r_v0x, r_v0y;
    logic                               r_enough;
    logic                               r_inside, r_too_few, r_ovf_out;

    logic                           w_in_xfer, w_append, w_query, w_out_load;
    logic                           w_last_edge, w_hit;
    logic [MAX_VERTICES-1:0]        w_load;
    pip_pkg::t_edge                 w_edge;

    logic signed [pip_pkg::COORD_W-1:0] w_cell_x [MAX_VERTICES];
    logic signed [pip_pkg::COORD_W-1:0] w_cell_y [MAX_VERTICES];

    assign o_in_ready = (r_state == pip_pkg::ST_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_append   = w_in_xfer && (pip_pkg::t_mode'(i_mode) == pip_pkg::MODE_APPEND);
    assign w_query    = w_in_xfer && (pip_pkg::t_mode'(i_mode) == pip_pkg::MODE_QUERY);
    assign w_out_load = (r_state == pip_pkg::ST_FINISH) && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Vertex ring: cell i holds vertex i between queries. A query rotates
    // the ring a full turn, so cell 0 shows vertex k at scan step k and
    // cell 1 shows vertex k + 1; the ring is back in place afterwards.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
        assign w_load[gi] = w_append && (r_count == CW'(gi));

        pip_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (r_state == pip_pkg::ST_SCAN),
            .i_load  (w_load[gi]),
            .i_wx    (i_px),
            .i_wy    (i_py),
            .i_nx    (w_cell_x[(gi + 1) % MAX_VERTICES]),
            .i_ny    (w_cell_y[(gi + 1) % MAX_VERTICES]),
            .o_x     (w_cell_x[gi]),
            .o_y     (w_cell_y[gi])
        );
    end

    // ------------------------------------------------------------------
    // Edge feed: edge k runs from vertex k to vertex k + 1; the closing
    // edge takes vertex 0 from the copy latched at query transfer.
    // ------------------------------------------------------------------
    assign w_last_edge = (CW'(r_step) + CW'(1)) == r_count;

    always_comb begin
        w_edge.valid = (r_state == pip_pkg::ST_SCAN) && r_enough && (CW'(r_step) < r_count);
        w_edge.ax    = w_cell_x[0];
        w_edge.ay    = w_cell_y[0];
        w_edge.bx    = w_last_edge ? r_v0x : w_cell_x[1];
        w_edge.by    = w_last_edge ? r_v0y : w_cell_y[1];
    end

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_query),
        .i_edge  (w_edge),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_hit   (w_hit)
    );

    // ------------------------------------------------------------------
    // Sequencer: idle takes items; scan walks all cells; drain waits for
    // the edge pipeline; finish hands the result to the output register.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_step      = r_step;
        n_drain     = r_drain;
        n_out_valid = w_out_load || (r_out_valid && !i_out_ready);

        unique case (r_state)
            pip_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    unique case (pip_pkg::t_mode'(i_mode))
                        pip_pkg::MODE_CLEAR: begin
                            n_count    = '0;
                            n_overflow = 1'b0;
                        end
                        pip_pkg::MODE_APPEND: begin
                            // drop the vertex when the ring is full
                            if (r_count == CW'(MAX_VERTICES)) begin
                                n_overflow = 1'b1;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        pip_pkg::MODE_QUERY: begin
                            n_state = pip_pkg::ST_SCAN;
                            n_step  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pip_pkg::ST_SCAN: begin
                n_step = r_step + SW'(1);
                if (r_step == SW'(MAX_VERTICES - 1)) begin
                    n_state = pip_pkg::ST_DRAIN;
                    n_drain = '0;
                end
            end
            pip_pkg::ST_DRAIN: begin
                n_drain = r_drain + pip_pkg::DRAIN_W'(1);
                if (r_drain == pip_pkg::DRAIN_W'(pip_pkg::DRAIN_CYCLES - 1)) begin
                    n_state = pip_pkg::ST_FINISH;
                end
            end
            pip_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (w_out_load) begin
                    n_state = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pip_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pip_pkg::ST_IDLE;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_step      <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_step      <= n_step;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    // Query context: point, vertex 0 for the closing edge, size check
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qx     <= i_px;
            r_qy     <= i_py;
            r_v0x    <= w_cell_x[0];
            r_v0y    <= w_cell_y[0];
            r_enough <= (r_count >= CW'(pip_pkg::MIN_VERTICES));
        end
    end

    // Result register parts the sequencer from the downstream stall
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_inside  <= r_enough && w_hit;
            r_too_few <= !r_enough;
            r_ovf_out <= r_overflow;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_inside_res       = r_inside;
    assign o_too_few_vertices = r_too_few;
    assign o_overflowed       = r_ovf_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond ring size");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CW'(MAX_VERTICES)))
        else $error("overflow flag set while ring not full");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == pip_pkg::ST_FINISH))
        else $error("result valid raised outside finish");

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pip_pkg::ST_SCAN && $past(r_state) == pip_pkg::ST_SCAN)
            |-> (r_step == $past(r_step) + SW'(1)))
        else $error("scan step skipped");
`endif

endmodule

[sv/pip_cell.sv]
// ----------------------------------------------------------------------------
// pip_cell
// One vertex cell of the polygon ring: loads on append, rotates on scan.
// ----------------------------------------------------------------------------
module pip_cell (
    input  logic                                i_clk,
    input  logic                                i_shift,
    input  logic                                i_load,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_wx,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_wy,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_nx,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_ny,
    output logic signed [pip_pkg::COORD_W-1:0]  o_x,
    output logic signed [pip_pkg::COORD_W-1:0]  o_y
);

    logic signed [pip_pkg::COORD_W-1:0] r_x;
    logic signed [pip_pkg::COORD_W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_wx;
            r_y <= i_wy;
        end else if (i_shift) begin
            // take the neighbor's vertex
            r_x <= i_nx;
            r_y <= i_ny;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

[sv/pip_edge.sv]
// ----------------------------------------------------------------------------
// pip_edge
// Three-stage edge test against the query ray, with hit parity accumulation.
// ----------------------------------------------------------------------------
module pip_edge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  pip_pkg::t_edge                      i_edge,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_qx,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_qy,
    output logic                                o_hit
);

    localparam int DW  = pip_pkg::DIFF_W;
    localparam int RW  = pip_pkg::RAYD_W;
    localparam int P1W = 2 * DW;
    localparam int P2W = DW + RW;
    localparam int V1W = P1W + 1;
    localparam int V2W = P2W + 1;

    typedef struct packed {
        logic ay_eq;
        logic ay_lt;
        logic by_eq;
        logic by_lt;
        logic ax_ge;
        logic bx_ge;
        logic box;
    } t_flags;

    logic signed [pip_pkg::COORD_W-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [DW-1:0]  n1_dy, n1_dx, n1_qxb, n1_qyb;
    logic signed [RW-1:0]  n1_rxb;
    t_flags                n1_flags;

    logic                  r1_valid;
    logic signed [DW-1:0]  r1_dy, r1_dx, r1_qxb, r1_qyb;
    logic signed [RW-1:0]  r1_rxb;
    t_flags                r1_flags;

    logic                  r2_valid;
    logic signed [P1W-1:0] r2_p1a, r2_pd;
    logic signed [P2W-1:0] r2_p2a;
    t_flags                r2_flags;

    logic signed [V1W-1:0] w_v1;
    logic signed [V2W-1:0] w_v2;
    pip_pkg::t_orient      w_o1, w_o2, w_o3, w_o4;
    logic                  w_crossed;

    logic                  r_decided, r_dec_val, r_parity;
    logic                  n_decided, n_dec_val, n_parity;

    // Stage 1: differences and compares
    assign w_ax = $signed(i_edge.ax);
    assign w_ay = $signed(i_edge.ay);
    assign w_bx = $signed(i_edge.bx);
    assign w_by = $signed(i_edge.by);

    always_comb begin
        n1_dy  = DW'(w_by) - DW'(w_ay);
        n1_dx  = DW'(w_bx) - DW'(w_ax);
        n1_qxb = DW'(i_qx) - DW'(w_bx);
        n1_qyb = DW'(i_qy) - DW'(w_by);
        n1_rxb = RW'(pip_pkg::RAY_END_X) - RW'(w_bx);
        n1_flags.ay_eq = (w_ay == i_qy);
        n1_flags.ay_lt = (w_ay <  i_qy);
        n1_flags.by_eq = (w_by == i_qy);
        n1_flags.by_lt = (w_by <  i_qy);
        n1_flags.ax_ge = (w_ax >= i_qx);
        n1_flags.bx_ge = (w_bx >= i_qx);
        n1_flags.box   = (i_qx <= w_ax || i_qx <= w_bx) && (i_qx >= w_ax || i_qx >= w_bx) &&
                         (i_qy <= w_ay || i_qy <= w_by) && (i_qy >= w_ay || i_qy >= w_by);
    end

    always_ff @(posedge i_clk) begin
        r1_dy    <= n1_dy;
        r1_dx    <= n1_dx;
        r1_qxb   <= n1_qxb;
        r1_qyb   <= n1_qyb;
        r1_rxb   <= n1_rxb;
        r1_flags <= n1_flags;
    end

    // Stage 2: orientation products (the dx * (qy - by) term is shared)
    always_ff @(posedge i_clk) begin
        r2_p1a   <= P1W'(r1_dy) * P1W'(r1_qxb);
        r2_pd    <= P1W'(r1_dx) * P1W'(r1_qyb);
        r2_p2a   <= P2W'(r1_dy) * P2W'(r1_rxb);
        r2_flags <= r1_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_edge.valid;
            r2_valid <= r1_valid;
        end
    end

    // Stage 3: signs, crossing test, accumulate
    always_comb begin
        w_v1 = V1W'(r2_p1a) - V1W'(r2_pd);
        w_v2 = V2W'(r2_p2a) - V2W'(r2_pd);
        w_o1 = pip_pkg::orient_of(w_v1 == '0, w_v1[V1W-1]);
        w_o2 = pip_pkg::orient_of(w_v2 == '0, w_v2[V2W-1]);
        // ray-side orientations reduce to the sign of the vertex y against qy
        w_o3 = pip_pkg::orient_of(r2_flags.ay_eq, !r2_flags.ay_lt);
        w_o4 = pip_pkg::orient_of(r2_flags.by_eq, !r2_flags.by_lt);
        w_crossed = (w_o1 != w_o2 && w_o3 != w_o4) ||
                    (w_o1 == pip_pkg::ORI_COLIN && r2_flags.box) ||
                    (r2_flags.ay_eq && r2_flags.ax_ge) ||
                    (r2_flags.by_eq && r2_flags.bx_ge);

        n_decided = r_decided;
        n_dec_val = r_dec_val;
        n_parity  = r_parity;
        if (i_start) begin
            n_decided = 1'b0;
            n_dec_val = 1'b0;
            n_parity  = 1'b0;
        end else if (r2_valid && !r_decided && w_crossed) begin
            if (w_o1 == pip_pkg::ORI_COLIN) begin
                // point on the edge's line: the edge settles the answer
                n_decided = 1'b1;
                n_dec_val = r2_flags.box;
            end else if (!r2_flags.by_eq) begin
                n_parity = !r_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decided <= 1'b0;
            r_dec_val <= 1'b0;
            r_parity  <= 1'b0;
        end else begin
            r_decided <= n_decided;
            r_dec_val <= n_dec_val;
            r_parity  <= n_parity;
        end
    end

    assign o_hit = r_decided ? r_dec_val : r_parity;

endmodule
